[src/iole_pkg.sv]
// Shared types and codes for the indexed ordered list engine.
// No dependencies; imported by indexed_ordered_list_engine.
package iole_pkg;

    typedef enum logic [2:0] {
        REQ_INSERT  = 3'd0,
        REQ_DELETE  = 3'd1,
        REQ_READ    = 3'd2,
        REQ_FIND    = 3'd3,
        REQ_REPLACE = 3'd4,
        REQ_CLEAR   = 3'd5
    } req_code_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_NONE  = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_UP_RD,
        S_UP_WR,
        S_DOWN_RD,
        S_DOWN_WR,
        S_READ_RD,
        S_READ_WAIT,
        S_FIND_RD,
        S_FIND_CMP,
        S_FINISH
    } state_t;

    localparam int POS_W   = 7;
    localparam int DATA_W  = 32;
    localparam int FOUND_W = 6;
    localparam int LEN_W   = 7;

endpackage

[src/indexed_ordered_list_engine.sv]
// Indexed ordered list engine: top level with list memory and sequencer.
// Depends on iole_pkg.
//
// Keeps an ordered list of up to CAPACITY signed 32-bit entries in a single-port
// style memory (one read and one write per cycle, registered read data). Each beat
// on the request channel gives exactly one beat on the result channel. Each entry
// move or compare is a memory read, then a write or compare. in_stall is high
// while a request is being worked on; a new request is taken while the previous
// result still waits on out_stall.
module indexed_ordered_list_engine
    import iole_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [2:0]                req_type,
    input  logic [POS_W-1:0]          position,
    input  logic signed [DATA_W-1:0]  value,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [1:0]                status,
    output logic signed [DATA_W-1:0]  read_value,
    output logic [FOUND_W-1:0]        found_position,
    output logic [LEN_W-1:0]          list_length
);

    localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    state_t                   state_reg, state_next;
    logic [2:0]               req_reg;
    logic [POS_W-1:0]         pos_reg;
    logic signed [DATA_W-1:0] val_reg;
    logic [CMPW-1:0]          idx_reg, idx_next;
    logic [CW-1:0]            count_reg, count_next;
    status_t                  res_status_reg, res_status_next;
    logic signed [DATA_W-1:0] res_read_reg, res_read_next;
    logic [FOUND_W-1:0]       res_found_reg, res_found_next;
    logic                     out_valid_reg, out_valid_next;
    logic [1:0]               status_reg;
    logic signed [DATA_W-1:0] read_value_reg;
    logic [FOUND_W-1:0]       found_position_reg;
    logic [LEN_W-1:0]         list_length_reg;

    logic [DATA_W-1:0]        mem [CAPACITY];
    logic [DATA_W-1:0]        rdata_reg;
    logic                     mem_rd_en, mem_wr_en;
    logic [AW-1:0]            mem_raddr, mem_waddr;
    logic [DATA_W-1:0]        mem_wdata;

    logic                     in_fire, out_free;
    logic [CMPW-1:0]          pos_ext, count_ext, idx_step, cmp_a, cmp_b;
    logic                     pos_gt_count, pos_ge_count, is_full, cmp_lt, is_match;
    logic [AW-1:0]            pos_addr, idx_addr, step_addr;

    assign in_stall = (state_reg != S_IDLE);
    assign in_fire  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    assign pos_ext      = CMPW'(pos_reg);
    assign count_ext    = CMPW'(count_reg);
    assign pos_gt_count = pos_ext > count_ext;
    assign pos_ge_count = pos_ext >= count_ext;
    assign is_full      = count_ext == CMPW'(CAPACITY);
    assign pos_addr     = AW'(pos_ext);
    assign idx_addr     = AW'(idx_reg);
    assign step_addr    = AW'(idx_step);

    // shared index unit: one adder and one comparator
    always_comb
    begin
        if (state_reg == S_UP_RD || state_reg == S_UP_WR)
        begin
            idx_step = idx_reg - CMPW'(1);
        end
        else
        begin
            idx_step = idx_reg + CMPW'(1);
        end
        unique case (state_reg)
            S_UP_RD:
            begin
                cmp_a = pos_ext;
                cmp_b = idx_reg;
            end
            S_DOWN_RD:
            begin
                cmp_a = idx_step;
                cmp_b = count_ext;
            end
            default:
            begin
                cmp_a = idx_reg;
                cmp_b = count_ext;
            end
        endcase
    end

    assign cmp_lt   = cmp_a < cmp_b;
    assign is_match = rdata_reg == DATA_W'(val_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_FINISH;
                unique case (req_reg)
                    REQ_INSERT:
                    begin
                        if (!pos_gt_count && !is_full)
                        begin
                            state_next = S_UP_RD;
                        end
                    end
                    REQ_DELETE:
                    begin
                        if (!pos_ge_count)
                        begin
                            state_next = S_DOWN_RD;
                        end
                    end
                    REQ_READ:
                    begin
                        if (!pos_ge_count)
                        begin
                            state_next = S_READ_RD;
                        end
                    end
                    REQ_FIND:
                    begin
                        state_next = S_FIND_RD;
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_UP_RD:     state_next = cmp_lt ? S_UP_WR : S_FINISH;
            S_UP_WR:     state_next = S_UP_RD;
            S_DOWN_RD:   state_next = cmp_lt ? S_DOWN_WR : S_FINISH;
            S_DOWN_WR:   state_next = S_DOWN_RD;
            S_READ_RD:   state_next = S_READ_WAIT;
            S_READ_WAIT: state_next = S_FINISH;
            S_FIND_RD:   state_next = cmp_lt ? S_FIND_CMP : S_FINISH;
            S_FIND_CMP:  state_next = is_match ? S_FINISH : S_FIND_RD;
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        idx_next        = idx_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_read_next   = res_read_reg;
        res_found_next  = res_found_reg;
        out_valid_next  = out_valid_reg && out_stall;
        mem_rd_en       = 1'b0;
        mem_raddr       = idx_addr;
        mem_wr_en       = 1'b0;
        mem_waddr       = idx_addr;
        mem_wdata       = rdata_reg;
        unique case (state_reg)
            S_DISPATCH:
            begin
                res_status_next = ST_OK;
                res_read_next   = '0;
                res_found_next  = '0;
                unique case (req_reg)
                    REQ_INSERT:
                    begin
                        if (pos_gt_count)
                        begin
                            res_status_next = ST_RANGE;
                        end
                        else if (is_full)
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            idx_next = count_ext;
                        end
                    end
                    REQ_DELETE:
                    begin
                        if (pos_ge_count)
                        begin
                            res_status_next = ST_RANGE;
                        end
                        else
                        begin
                            idx_next = pos_ext;
                        end
                    end
                    REQ_READ:
                    begin
                        if (pos_ge_count)
                        begin
                            res_status_next = ST_RANGE;
                        end
                    end
                    REQ_FIND:
                    begin
                        res_status_next = ST_NONE;
                        idx_next        = '0;
                    end
                    REQ_REPLACE:
                    begin
                        if (pos_ge_count)
                        begin
                            res_status_next = ST_RANGE;
                        end
                        else
                        begin
                            mem_wr_en = 1'b1;
                            mem_waddr = pos_addr;
                            mem_wdata = DATA_W'(val_reg);
                        end
                    end
                    REQ_CLEAR:
                    begin
                        count_next = '0;
                    end
                    default:
                    begin
                        res_status_next = ST_RANGE;
                    end
                endcase
            end
            S_UP_RD:
            begin
                if (cmp_lt)
                begin
                    mem_rd_en = 1'b1;
                    mem_raddr = step_addr;
                end
                else
                begin
                    mem_wr_en  = 1'b1;
                    mem_waddr  = pos_addr;
                    mem_wdata  = DATA_W'(val_reg);
                    count_next = count_reg + CW'(1);
                end
            end
            S_UP_WR:
            begin
                mem_wr_en = 1'b1;
                idx_next  = idx_step;
            end
            S_DOWN_RD:
            begin
                if (cmp_lt)
                begin
                    mem_rd_en = 1'b1;
                    mem_raddr = step_addr;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                end
            end
            S_DOWN_WR:
            begin
                mem_wr_en = 1'b1;
                idx_next  = idx_step;
            end
            S_READ_RD:
            begin
                mem_rd_en = 1'b1;
                mem_raddr = pos_addr;
            end
            S_READ_WAIT:
            begin
                res_read_next = rdata_reg;
            end
            S_FIND_RD:
            begin
                if (cmp_lt)
                begin
                    mem_rd_en = 1'b1;
                end
            end
            S_FIND_CMP:
            begin
                if (is_match)
                begin
                    res_status_next = ST_OK;
                    res_found_next  = idx_reg[FOUND_W-1:0];
                end
                else
                begin
                    idx_next = idx_step;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            req_reg <= req_type;
            pos_reg <= position;
            val_reg <= value;
        end
        idx_reg        <= idx_next;
        res_status_reg <= res_status_next;
        res_read_reg   <= res_read_next;
        res_found_reg  <= res_found_next;
        if (state_reg == S_FINISH && out_free)
        begin
            status_reg         <= res_status_reg;
            read_value_reg     <= res_read_reg;
            found_position_reg <= res_found_reg;
            list_length_reg    <= count_ext[LEN_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_rd_en)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign read_value     = read_value_reg;
    assign found_position = found_position_reg;
    assign list_length    = list_length_reg;

endmodule

[tb/tb.sv]
// Self-checking testbench for indexed_ordered_list_engine: directed table, then random traffic.
// Each result is checked against its table row or a predictor of the list contents and length.
// Depends on iole_pkg and the indexed_ordered_list_engine RTL.
module tb;
    import iole_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_CAP = 64;
    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 200;
    localparam int RANDOM_ITEMS = 600;
    localparam logic [2:0] REQ_UNUSED_LO = 3'd6;
    localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

    typedef struct packed {
        status_t            status;
        logic [DATA_W-1:0]  rd;
        logic [FOUND_W-1:0] found;
        logic [LEN_W-1:0]   len;
    } list_result_t;

    typedef struct {
        logic [2:0]        rq;
        logic [POS_W-1:0]  ps;
        logic [DATA_W-1:0] vl;
        bit                known;
        list_result_t      want;
    } req_row_t;

    logic                     clk;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [2:0]               req_type = REQ_READ;
    logic [POS_W-1:0]         position = '0;
    logic signed [DATA_W-1:0] value = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [1:0]               status;
    logic signed [DATA_W-1:0] read_value;
    logic [FOUND_W-1:0]       found_position;
    logic [LEN_W-1:0]         list_length;

    logic [DATA_W-1:0] list_mem [LIST_CAP];
    int                list_len = 0;
    list_result_t      pending_results [$];
    req_row_t          directed_rows [$];
    list_result_t      got_want;
    int                mismatches = 0;
    int                quiet_cycles = 0;
    int                stall_left = 0;
    bit                quiet = 1'b0;

    indexed_ordered_list_engine #(.CAPACITY(LIST_CAP)) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .req_type       (req_type),
        .position       (position),
        .value          (value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .read_value     (read_value),
        .found_position (found_position),
        .list_length    (list_length)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // list predictor: applies one request to the shadow list, returns its result
    function automatic list_result_t apply_request(input logic [2:0] rq,
                                                   input logic [POS_W-1:0] ps,
                                                   input logic [DATA_W-1:0] vl);
        list_result_t r;
        int i;
        r = '0;
        r.status = ST_OK;
        case (rq)
            REQ_INSERT:
                if (ps > list_len)
                    r.status = ST_RANGE;
                else if (list_len >= LIST_CAP)
                    r.status = ST_FULL;
                else
                begin
                    for (i = list_len; i > ps; i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[ps] = vl;
                    list_len++;
                end
            REQ_DELETE:
                if (ps >= list_len)
                    r.status = ST_RANGE;
                else
                begin
                    for (i = ps; i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i+1];
                    list_len--;
                end
            REQ_READ:
                if (ps >= list_len)
                    r.status = ST_RANGE;
                else
                    r.rd = list_mem[ps];
            REQ_FIND:
            begin
                r.status = ST_NONE;
                for (i = 0; i < list_len; i++)
                    if (r.status == ST_NONE && list_mem[i] == vl)
                    begin
                        r.status = ST_OK;
                        r.found = i[FOUND_W-1:0];
                    end
            end
            REQ_REPLACE:
                if (ps >= list_len)
                    r.status = ST_RANGE;
                else
                    list_mem[ps] = vl;
            REQ_CLEAR:
                list_len = 0;
            default:
                r.status = ST_RANGE;
        endcase
        r.len = list_len[LEN_W-1:0];
        return r;
    endfunction

    task automatic add_row(input logic [2:0] rq, input int ps, input logic [DATA_W-1:0] vl,
                           input bit known, input status_t st, input logic [DATA_W-1:0] rd,
                           input int fp, input int ln);
        req_row_t row;
        row.rq = rq;
        row.ps = ps[POS_W-1:0];
        row.vl = vl;
        row.known = known;
        row.want.status = st;
        row.want.rd = rd;
        row.want.found = fp[FOUND_W-1:0];
        row.want.len = ln[LEN_W-1:0];
        directed_rows.push_back(row);
    endtask

    // drives one request beat, waits for it to be taken, then records its expected result
    task automatic issue(input logic [2:0] rq, input logic [POS_W-1:0] ps,
                         input logic [DATA_W-1:0] vl, input bit known, input list_result_t want);
        list_result_t predicted;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= rq;
        position <= ps;
        value <= vl;
        do
            @(posedge clk);
        while (in_stall);
        predicted = apply_request(rq, ps, vl);
        pending_results.push_back(known ? want : predicted);
    endtask

    task automatic pick_request(input int ins_w, input int del_w, input int clr_w,
                                output logic [2:0] rq, output logic [POS_W-1:0] ps,
                                output logic [DATA_W-1:0] vl);
        int r;
        r = $urandom_range(0, 99);
        if (r < ins_w)
            rq = REQ_INSERT;
        else if (r < ins_w + del_w)
            rq = REQ_DELETE;
        else if (r < ins_w + del_w + clr_w)
            rq = REQ_CLEAR;
        else if (r < ins_w + del_w + clr_w + 2)
            rq = $urandom_range(0, 1) ? REQ_UNUSED_LO : REQ_UNUSED_HI;
        else
            case ($urandom_range(0, 2))
                0: rq = REQ_READ;
                1: rq = REQ_FIND;
                default: rq = REQ_REPLACE;
            endcase

        if (rq == REQ_INSERT)
            ps = POS_W'($urandom_range(0, list_len));
        else
            ps = (list_len > 0) ? POS_W'($urandom_range(0, list_len - 1)) : '0;
        if ($urandom_range(0, 7) == 0)
            ps = POS_W'($urandom_range(0, 127));

        if (rq == REQ_FIND && list_len > 0 && $urandom_range(0, 3) != 0)
            vl = list_mem[$urandom_range(0, list_len - 1)];
        else
            case ($urandom_range(0, 9))
                0:
                    case ($urandom_range(0, 3))
                        0: vl = 32'h8000_0000;
                        1: vl = 32'h7FFF_FFFF;
                        2: vl = 32'hFFFF_FFFF;
                        default: vl = '0;
                    endcase
                1, 2: vl = $urandom_range(0, 7);
                default: vl = $urandom;
            endcase
    endtask

    // result side: random stall bursts, none while quiet
    always @(posedge clk)
    begin
        if (quiet)
        begin
            stall_left = 0;
            out_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 6);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat with no request outstanding");
                mismatches++;
            end
            else
            begin
                got_want = pending_results.pop_front();
                if (status !== got_want.status)
                begin
                    $error("status: expected %0d, got %0d", got_want.status, status);
                    mismatches++;
                end
                if (read_value !== got_want.rd)
                begin
                    $error("read_value: expected %0d, got %0d", $signed(got_want.rd), read_value);
                    mismatches++;
                end
                if (found_position !== got_want.found)
                begin
                    $error("found_position: expected %0d, got %0d", got_want.found,
                           found_position);
                    mismatches++;
                end
                if (list_length !== got_want.len)
                begin
                    $error("list_length: expected %0d, got %0d", got_want.len, list_length);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        logic [2:0]        rq;
        logic [POS_W-1:0]  ps;
        logic [DATA_W-1:0] vl;
        list_result_t      none;
        int                phase;

        none = '0;
        // empty list: every indexed access is out of range, find misses
        add_row(REQ_READ,      0,   0,            1, ST_RANGE, 0, 0, 0);
        add_row(REQ_DELETE,    0,   0,            1, ST_RANGE, 0, 0, 0);
        add_row(REQ_REPLACE,   0,   5,            1, ST_RANGE, 0, 0, 0);
        add_row(REQ_FIND,      0,   0,            1, ST_NONE,  0, 0, 0);
        add_row(REQ_INSERT,    1,   9,            1, ST_RANGE, 0, 0, 0);
        add_row(REQ_INSERT,    0,   32'h7FFF_FFFF, 1, ST_OK,   0, 0, 1);
        add_row(REQ_INSERT,    0,   32'h8000_0000, 1, ST_OK,   0, 0, 2);
        add_row(REQ_INSERT,    2,   32'hFFFF_FFFF, 1, ST_OK,   0, 0, 3);
        add_row(REQ_READ,      0,   0,   1, ST_OK, 32'h8000_0000, 0, 3);
        add_row(REQ_READ,      2,   0,   1, ST_OK, 32'hFFFF_FFFF, 0, 3);
        add_row(REQ_FIND,      127, 32'h7FFF_FFFF, 1, ST_OK,   0, 1, 3);
        add_row(REQ_INSERT,    4,   1,            1, ST_RANGE, 0, 0, 3);
        add_row(REQ_REPLACE,   1,   0,            0, ST_OK,    0, 0, 0);
        add_row(REQ_FIND,      0,   0,            0, ST_OK,    0, 0, 0);
        add_row(REQ_UNUSED_LO, 127, 32'hFFFF_FFFF, 1, ST_RANGE, 0, 0, 3);
        add_row(REQ_UNUSED_HI, 0,   0,            1, ST_RANGE, 0, 0, 3);
        add_row(REQ_DELETE,    3,   0,            1, ST_RANGE, 0, 0, 3);
        add_row(REQ_READ,      127, 0,            1, ST_RANGE, 0, 0, 3);
        add_row(REQ_INSERT,    1,   0,            0, ST_OK,    0, 0, 0);
        add_row(REQ_FIND,      0,   0,            0, ST_OK,    0, 0, 0);
        add_row(REQ_DELETE,    0,   0,            0, ST_OK,    0, 0, 0);
        add_row(REQ_REPLACE,   2,   32'h8000_0000, 0, ST_OK,   0, 0, 0);
        add_row(REQ_CLEAR,     127, 123,          1, ST_OK,    0, 0, 0);
        add_row(REQ_READ,      0,   0,            1, ST_RANGE, 0, 0, 0);
        add_row(REQ_INSERT,    0,   42,           0, ST_OK,    0, 0, 0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[k])
            issue(directed_rows[k].rq, directed_rows[k].ps, directed_rows[k].vl,
                  directed_rows[k].known, directed_rows[k].want);

        // mixed traffic, then fill toward capacity, then drain, then mixed with no idling after its first quiet update
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            phase = n / (RANDOM_ITEMS / 4);
            if (n % 40 == 0)
                quiet = (phase == 3) || ($urandom_range(0, 3) == 0);
            case (phase)
                0: pick_request(40, 20, 2, rq, ps, vl);
                1: pick_request(70, 8, 0, rq, ps, vl);
                2: pick_request(8, 55, 0, rq, ps, vl);
                default: pick_request(40, 20, 2, rq, ps, vl);
            endcase
            issue(rq, ps, vl, 0, none);
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending_results.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

[filelist.f]
src/iole_pkg.sv
src/indexed_ordered_list_engine.sv
tb/tb.sv
